@@ rtl/core/fct_pkg.sv @@
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants for the frustum cull test: plane register
// layout, register indexes, test kinds and fixed-point formats.
// ----------------------------------------------------------------------------
package fct_pkg;

    // number of plane registers behind the configuration port
    localparam int PLANE_REGS   = 6;

    // normal components are Q1.14, 16 bits
    localparam int NORM_W       = 16;
    localparam int FRAC_BITS    = 14;

    // configuration port: 64-bit registers at byte address 8*i
    localparam int CFG_DATA_W   = 64;
    localparam int REG_ADDR_LSB = 3;
    localparam int REG_IDX_W    = 3;
    localparam int PADDR_W      = REG_ADDR_LSB + REG_IDX_W;

    typedef enum logic [REG_IDX_W-1:0] {
        PLANE_LEFT   = 3'd0,
        PLANE_RIGHT  = 3'd1,
        PLANE_BOTTOM = 3'd2,
        PLANE_TOP    = 3'd3,
        PLANE_NEAR   = 3'd4,
        PLANE_FAR    = 3'd5
    } plane_idx_t;

    // test kind carried with each item
    localparam logic FUNC_BOX    = 1'b0;
    localparam logic FUNC_SPHERE = 1'b1;

    // packed plane: d in the top 16 bits, nx in the bottom 16
    typedef struct packed {
        logic signed [NORM_W-1:0] d;
        logic signed [NORM_W-1:0] nz;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nx;
    } plane_t;

endpackage

@@ rtl/core/frustum_cull_test.sv @@
// ----------------------------------------------------------------------------
// frustum_cull_test
// Culls a box or sphere on up to six planes, one item per unstalled cycle.
// ----------------------------------------------------------------------------
// Each item passes through a chain of NUM_PLANES cells, one per plane, and
// each cell has two register stages (normal products, then distance sum and
// sign test). A new item is taken every cycle while the output is not
// stalled. Every stage has its own valid bit and holds its item only while
// the stage after it is full, so a stalled output fills the chain before
// in_ready drops. Planes are 64-bit registers at byte address 8*i (left,
// right, bottom, top, near, far), packed as nx in bits 15:0, ny, nz, then d
// in bits 63:48, normals in Q1.14; write them only while no item is in
// flight.
// ----------------------------------------------------------------------------
module frustum_cull_test
    import fct_pkg::*;
#(
    parameter int NUM_PLANES  = 6,
    parameter int COORD_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [CFG_DATA_W-1:0]         pwdata,
    output logic [CFG_DATA_W-1:0]         prdata,
    output logic                          pready,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic signed [COORD_WIDTH-1:0] min_x,
    input  logic signed [COORD_WIDTH-1:0] min_y,
    input  logic signed [COORD_WIDTH-1:0] min_z,
    input  logic signed [COORD_WIDTH-1:0] max_x,
    input  logic signed [COORD_WIDTH-1:0] max_y,
    input  logic signed [COORD_WIDTH-1:0] max_z,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] center_z,
    input  logic [COORD_WIDTH-2:0]        radius,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          culled
);

    plane_t                          planes [PLANE_REGS];

    logic                            lnk_valid [NUM_PLANES+1];
    logic                            lnk_ready [NUM_PLANES+1];
    logic                            lnk_func  [NUM_PLANES+1];
    logic [2:0][COORD_WIDTH-1:0]     lnk_lo    [NUM_PLANES+1];
    logic [2:0][COORD_WIDTH-1:0]     lnk_hi    [NUM_PLANES+1];
    logic [2:0][COORD_WIDTH-1:0]     lnk_ctr   [NUM_PLANES+1];
    logic [COORD_WIDTH-2:0]          lnk_rad   [NUM_PLANES+1];
    logic                            lnk_acc   [NUM_PLANES+1];

    fct_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes)
    );

    // head of the chain: axis 0 is x
    assign lnk_valid[0] = in_valid;
    assign in_ready     = lnk_ready[0];
    assign lnk_func[0]  = func;
    assign lnk_lo[0]    = {min_z, min_y, min_x};
    assign lnk_hi[0]    = {max_z, max_y, max_x};
    assign lnk_ctr[0]   = {center_z, center_y, center_x};
    assign lnk_rad[0]   = radius;
    assign lnk_acc[0]   = 1'b0;

    for (genvar i = 0; i < NUM_PLANES; i++)
    begin : g_cell
        fct_cell #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .plane      (planes[i]),
            .up_valid   (lnk_valid[i]),
            .up_ready   (lnk_ready[i]),
            .up_func    (lnk_func[i]),
            .up_lo      (lnk_lo[i]),
            .up_hi      (lnk_hi[i]),
            .up_ctr     (lnk_ctr[i]),
            .up_rad     (lnk_rad[i]),
            .up_acc     (lnk_acc[i]),
            .down_valid (lnk_valid[i+1]),
            .down_ready (lnk_ready[i+1]),
            .down_func  (lnk_func[i+1]),
            .down_lo    (lnk_lo[i+1]),
            .down_hi    (lnk_hi[i+1]),
            .down_ctr   (lnk_ctr[i+1]),
            .down_rad   (lnk_rad[i+1]),
            .down_acc   (lnk_acc[i+1])
        );
    end

    assign out_valid             = lnk_valid[NUM_PLANES];
    assign lnk_ready[NUM_PLANES] = out_ready;
    assign culled                = lnk_acc[NUM_PLANES];

`ifndef SYNTHESIS
    // input only stalls once every stage up to the output holds an item
    a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled while the chain still has room");

    a_left_write : assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready
            && paddr[PADDR_W-1:REG_ADDR_LSB] == PLANE_LEFT)
        |=> (planes[0] == $past(pwdata)))
        else $error("left plane write not stored");

    a_far_write : assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready
            && paddr[PADDR_W-1:REG_ADDR_LSB] == PLANE_FAR)
        |=> (planes[5] == $past(pwdata)))
        else $error("far plane write not stored");
`endif

endmodule

@@ rtl/core/fct_regs.sv @@
// ----------------------------------------------------------------------------
// fct_regs
// APB-style register file holding the six frustum planes.
// ----------------------------------------------------------------------------
module fct_regs
    import fct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output plane_t                planes [PLANE_REGS]
);

    plane_t                plane_reg [PLANE_REGS];
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  wr_en;
    logic                  idx_ok;

    assign reg_idx = paddr[PADDR_W-1:REG_ADDR_LSB];
    assign idx_ok  = (reg_idx < REG_IDX_W'(PLANE_REGS));
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLANE_REGS; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < PLANE_REGS; i++)
            begin
                if (reg_idx == REG_IDX_W'(i))
                begin
                    plane_reg[i] <= plane_t'(pwdata);
                end
            end
        end
    end

    // writes beyond the last plane are dropped and read back as zero
    always_comb
    begin
        prdata = '0;
        if (idx_ok)
        begin
            prdata = CFG_DATA_W'(plane_reg[reg_idx]);
        end
    end

    assign planes = plane_reg;

endmodule

@@ rtl/core/fct_cell.sv @@
// ----------------------------------------------------------------------------
// fct_cell
// One plane of the culling chain: picks the test point per axis, forms the
// three products, then sums the plane distance and ORs in this plane's cull.
// ----------------------------------------------------------------------------
module fct_cell
    import fct_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  plane_t                             plane,
    input  logic                               up_valid,
    output logic                               up_ready,
    input  logic                               up_func,
    input  logic [2:0][COORD_WIDTH-1:0]        up_lo,
    input  logic [2:0][COORD_WIDTH-1:0]        up_hi,
    input  logic [2:0][COORD_WIDTH-1:0]        up_ctr,
    input  logic [COORD_WIDTH-2:0]             up_rad,
    input  logic                               up_acc,
    output logic                               down_valid,
    input  logic                               down_ready,
    output logic                               down_func,
    output logic [2:0][COORD_WIDTH-1:0]        down_lo,
    output logic [2:0][COORD_WIDTH-1:0]        down_hi,
    output logic [2:0][COORD_WIDTH-1:0]        down_ctr,
    output logic [COORD_WIDTH-2:0]             down_rad,
    output logic                               down_acc
);

    localparam int PROD_W = NORM_W + COORD_WIDTH;
    localparam int D_W    = NORM_W + FRAC_BITS;
    localparam int R_W    = COORD_WIDTH - 1 + FRAC_BITS;
    localparam int MAX_W  = (PROD_W > D_W) ? ((PROD_W > R_W) ? PROD_W : R_W)
                                           : ((D_W > R_W) ? D_W : R_W);
    localparam int SUM_W  = MAX_W + 3;

    // stage a: selected points multiplied by the normal
    logic                               a_valid_reg;
    logic                               a_func_reg;
    logic [2:0][COORD_WIDTH-1:0]        a_lo_reg;
    logic [2:0][COORD_WIDTH-1:0]        a_hi_reg;
    logic [2:0][COORD_WIDTH-1:0]        a_ctr_reg;
    logic [COORD_WIDTH-2:0]             a_rad_reg;
    logic                               a_acc_reg;
    logic signed [PROD_W-1:0]           a_prod_reg [3];

    // stage b: item plus running cull flag
    logic                               b_valid_reg;
    logic                               b_func_reg;
    logic [2:0][COORD_WIDTH-1:0]        b_lo_reg;
    logic [2:0][COORD_WIDTH-1:0]        b_hi_reg;
    logic [2:0][COORD_WIDTH-1:0]        b_ctr_reg;
    logic [COORD_WIDTH-2:0]             b_rad_reg;
    logic                               b_acc_reg;

    logic signed [NORM_W-1:0]           nrm [3];
    logic signed [COORD_WIDTH-1:0]      sel [3];
    logic signed [PROD_W-1:0]           prod_next [3];
    logic signed [SUM_W-1:0]            plane_dist;
    logic                               b_acc_next;
    logic                               a_ready;
    logic                               b_ready;

    assign b_ready  = !b_valid_reg || down_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign up_ready = a_ready;

    always_comb
    begin
        nrm[0] = plane.nx;
        nrm[1] = plane.ny;
        nrm[2] = plane.nz;
        for (int k = 0; k < 3; k++)
        begin
            // box: corner along the normal, zero component takes the minimum
            if (up_func == FUNC_SPHERE)
            begin
                sel[k] = $signed(up_ctr[k]);
            end
            else if (!nrm[k][NORM_W-1] && (nrm[k] != '0))
            begin
                sel[k] = $signed(up_hi[k]);
            end
            else
            begin
                sel[k] = $signed(up_lo[k]);
            end
            prod_next[k] = nrm[k] * sel[k];
        end
    end

    // sphere folds the radius into the distance so both tests check the sign
    always_comb
    begin
        plane_dist = SUM_W'(a_prod_reg[0]) + SUM_W'(a_prod_reg[1]) + SUM_W'(a_prod_reg[2])
                   + (SUM_W'(plane.d) <<< FRAC_BITS);
        if (a_func_reg == FUNC_SPHERE)
        begin
            plane_dist = plane_dist + $signed(SUM_W'(a_rad_reg) << FRAC_BITS);
        end
        b_acc_next = a_acc_reg || plane_dist[SUM_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= up_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && a_ready)
        begin
            a_func_reg <= up_func;
            a_lo_reg   <= up_lo;
            a_hi_reg   <= up_hi;
            a_ctr_reg  <= up_ctr;
            a_rad_reg  <= up_rad;
            a_acc_reg  <= up_acc;
            for (int k = 0; k < 3; k++)
            begin
                a_prod_reg[k] <= prod_next[k];
            end
        end
        if (a_valid_reg && b_ready)
        begin
            b_func_reg <= a_func_reg;
            b_lo_reg   <= a_lo_reg;
            b_hi_reg   <= a_hi_reg;
            b_ctr_reg  <= a_ctr_reg;
            b_rad_reg  <= a_rad_reg;
            b_acc_reg  <= b_acc_next;
        end
    end

    assign down_valid = b_valid_reg;
    assign down_func  = b_func_reg;
    assign down_lo    = b_lo_reg;
    assign down_hi    = b_hi_reg;
    assign down_ctr   = b_ctr_reg;
    assign down_rad   = b_rad_reg;
    assign down_acc   = b_acc_reg;

endmodule

@@ bench/frustum_cull_checker.sv @@
// ----------------------------------------------------------------------------
// frustum_cull_checker
// Watches the plane register port and both item channels of the frustum cull
// test, keeps its own copy of the six planes, predicts the cull flag of each
// accepted item and compares it with the results in order. Register reads
// are checked against the shadow planes as well.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module frustum_cull_checker
    import fct_pkg::*;
#(
    parameter int NUM_PLANES  = 6,
    parameter int COORD_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [CFG_DATA_W-1:0]         pwdata,
    input  logic [CFG_DATA_W-1:0]         prdata,
    input  logic                          pready,

    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          func,
    input  logic signed [COORD_WIDTH-1:0] min_x,
    input  logic signed [COORD_WIDTH-1:0] min_y,
    input  logic signed [COORD_WIDTH-1:0] min_z,
    input  logic signed [COORD_WIDTH-1:0] max_x,
    input  logic signed [COORD_WIDTH-1:0] max_y,
    input  logic signed [COORD_WIDTH-1:0] max_z,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] center_z,
    input  logic [COORD_WIDTH-2:0]        radius,

    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          culled,

    output int                            fail_count,
    output int                            pending
);

    localparam longint Q_ONE = longint'(1) << FRAC_BITS;

    plane_t               shadow_planes [PLANE_REGS] = '{default: '0};
    logic                 culled_expected [$];
    logic                 want;
    logic [REG_IDX_W-1:0] reg_idx;
    int                   fails = 0;
    int                   i;

    // exact plane distances in Q.14, box uses the corner along each normal
    function automatic logic predict_culled(input logic kind,
                                            input longint lo_x, lo_y, lo_z,
                                            input longint hi_x, hi_y, hi_z,
                                            input longint c_x, c_y, c_z,
                                            input longint rad);
        longint nx, ny, nz, d, plane_dist;
        logic   hit;
        int     p;
        hit = 1'b0;
        for (p = 0; p < NUM_PLANES && p < PLANE_REGS; p++)
        begin
            nx         = $signed(shadow_planes[p].nx);
            ny         = $signed(shadow_planes[p].ny);
            nz         = $signed(shadow_planes[p].nz);
            d          = $signed(shadow_planes[p].d);
            plane_dist = d * Q_ONE;
            if (kind == FUNC_BOX)
            begin
                plane_dist += nx * ((nx > 0) ? hi_x : lo_x);
                plane_dist += ny * ((ny > 0) ? hi_y : lo_y);
                plane_dist += nz * ((nz > 0) ? hi_z : lo_z);
                if (plane_dist < 0)
                    hit = 1'b1;
            end
            else
            begin
                plane_dist += nx * c_x + ny * c_y + nz * c_z;
                if (plane_dist < -(rad * Q_ONE))
                    hit = 1'b1;
            end
        end
        return hit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (i = 0; i < PLANE_REGS; i++)
                shadow_planes[i] = '0;
            culled_expected.delete();
            pending    <= 0;
            fail_count <= fails;
        end
        else
        begin
            reg_idx = paddr[PADDR_W-1:REG_ADDR_LSB];
            // writes to indexes past the last plane are dropped
            if (psel && penable && pready && reg_idx < PLANE_REGS)
            begin
                if (!pwrite && prdata !== shadow_planes[reg_idx])
                begin
                    $display("%0t: plane register %0d readback, expected %h actual %h",
                             $time, reg_idx, shadow_planes[reg_idx], prdata);
                    fails++;
                end
                if (pwrite)
                    shadow_planes[reg_idx] = pwdata;
            end

            if (out_valid && out_ready)
            begin
                if (culled_expected.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual culled=%0b",
                             $time, culled);
                    fails++;
                end
                else
                begin
                    want = culled_expected.pop_front();
                    if (culled !== want)
                    begin
                        $display("%0t: culled mismatch, expected %0b actual %0b",
                                 $time, want, culled);
                        fails++;
                    end
                end
            end

            if (in_valid && in_ready)
                culled_expected.push_back(predict_culled(func,
                    min_x, min_y, min_z, max_x, max_y, max_z,
                    center_x, center_y, center_z, radius));

            pending    <= culled_expected.size();
            fail_count <= fails;
        end
    end

endmodule

@@ bench/tb_frustum_cull_test.sv @@
// ----------------------------------------------------------------------------
// tb_frustum_cull_test
// Drives the frustum cull test with directed boxes and spheres around plane
// boundaries, then random items under several plane settings and idle
// patterns, including long output stalls. The checker module predicts and
// compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_frustum_cull_test;
    import fct_pkg::*;

    localparam int NPLANES       = 6;
    localparam int COORD_W       = 16;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 205;
    localparam int HOLD_CYCLES   = 80;
    localparam int CYCLE_LIMIT   = 200000;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [COORD_W-2:0] radius_t;
    typedef logic signed [NORM_W-1:0]  norm_t;

    typedef struct packed {
        logic         kind;
        coord_t [2:0] lo;
        coord_t [2:0] hi;
        coord_t [2:0] ctr;
        radius_t      rad;
    } cull_item_t;

    typedef enum int {PL_ZERO, PL_FRUSTUM, PL_MAX, PL_MIN, PL_NOISE} plane_style_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [REG_IDX_W-1:0] SPARE_IDX_FIRST = REG_IDX_W'(PLANE_REGS);
    localparam logic [REG_IDX_W-1:0] SPARE_IDX_LAST  = '1;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel, penable, pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [CFG_DATA_W-1:0] pwdata, prdata;
    logic                  pready;
    logic                  in_valid, in_ready, func;
    coord_t                min_x, min_y, min_z, max_x, max_y, max_z;
    coord_t                center_x, center_y, center_z;
    radius_t               radius;
    logic                  out_valid, out_ready, culled;
    int                    fail_count, pending;
    int                    snd_idle_pct, rcv_idle_pct;
    int                    stall_requests = 0;
    int                    stalls_done;
    int unsigned           cycle_count;

    always #5 clk = ~clk;

    frustum_cull_test #(.NUM_PLANES(NPLANES), .COORD_WIDTH(COORD_W)) dut (.*);

    frustum_cull_checker #(.NUM_PLANES(NPLANES), .COORD_WIDTH(COORD_W)) cull_check (.*);

    function automatic coord_t rand_coord();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? COORD_MAX : COORD_MIN;
            1, 2, 3: return coord_t'($urandom);
            default: return coord_t'(int'($urandom_range(1200)) - 600);
        endcase
    endfunction

    function automatic cull_item_t make_item();
        cull_item_t it;
        coord_t     a, b;
        int         k;
        it.kind = $urandom_range(1) ? FUNC_SPHERE : FUNC_BOX;
        for (k = 0; k < 3; k++)
        begin
            a = rand_coord();
            b = rand_coord();
            // mostly ordered boxes, a few left inverted
            if (a > b && $urandom_range(9) != 0)
            begin
                it.lo[k] = b;
                it.hi[k] = a;
            end
            else
            begin
                it.lo[k] = a;
                it.hi[k] = b;
            end
            it.ctr[k] = rand_coord();
        end
        case ($urandom_range(7))
            0:       it.rad = '0;
            1:       it.rad = '1;
            2, 3:    it.rad = radius_t'($urandom);
            default: it.rad = radius_t'($urandom_range(800));
        endcase
        return it;
    endfunction

    // sphere fields stay random, the block must ignore them
    function automatic cull_item_t box_item(input int lx, ly, lz, hx, hy, hz);
        cull_item_t it;
        it      = make_item();
        it.kind = FUNC_BOX;
        it.lo   = {coord_t'(lz), coord_t'(ly), coord_t'(lx)};
        it.hi   = {coord_t'(hz), coord_t'(hy), coord_t'(hx)};
        return it;
    endfunction

    function automatic cull_item_t sphere_item(input int cx, cy, cz, r);
        cull_item_t it;
        it      = make_item();
        it.kind = FUNC_SPHERE;
        it.ctr  = {coord_t'(cz), coord_t'(cy), coord_t'(cx)};
        it.rad  = radius_t'(r);
        return it;
    endfunction

    function automatic plane_t make_plane(input plane_style_t style);
        plane_t pl;
        case (style)
            PL_ZERO:  pl = '0;
            PL_MAX:   pl = {4{16'h7FFF}};
            PL_MIN:   pl = {4{16'h8000}};
            PL_NOISE: pl = {$urandom, $urandom};
            default:
            begin
                pl.nx = norm_t'(int'($urandom_range(32768)) - 16384);
                pl.ny = norm_t'(int'($urandom_range(32768)) - 16384);
                pl.nz = norm_t'(int'($urandom_range(32768)) - 16384);
                pl.d  = norm_t'(int'($urandom_range(4000)) - 800);
            end
        endcase
        return pl;
    endfunction

    task automatic cfg_access(input logic write, input logic [REG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, {REG_ADDR_LSB{1'b0}}};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic offer(input cull_item_t it, input bit no_gaps);
        if (!no_gaps)
        begin
            while ($urandom_range(99) < snd_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        func     <= it.kind;
        min_x    <= it.lo[0];
        min_y    <= it.lo[1];
        min_z    <= it.lo[2];
        max_x    <= it.hi[0];
        max_y    <= it.hi[1];
        max_z    <= it.hi[2];
        center_x <= it.ctr[0];
        center_y <= it.ctr[1];
        center_z <= it.ctr[2];
        radius   <= it.rad;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (2 * NPLANES) @(posedge clk);
    endtask

    task automatic load_planes(input int ph);
        plane_style_t style;
        int           r;
        for (r = 0; r < PLANE_REGS; r++)
        begin
            case (ph)
                1:       style = PL_MAX;
                2:       style = PL_MIN;
                3:       style = PL_NOISE;
                5, 7:    style = plane_style_t'($urandom_range(PL_NOISE));
                default: style = PL_FRUSTUM;
            endcase
            cfg_access(1'b1, REG_IDX_W'(r), make_plane(style));
        end
        for (r = 0; r < PLANE_REGS; r++)
            cfg_access(1'b0, REG_IDX_W'(r), '0);
    endtask

    // receiver side, with a long hold-off on request
    initial
    begin
        out_ready   = 1'b0;
        stalls_done = 0;
        forever
        begin
            @(posedge clk);
            if (stalls_done != stall_requests)
            begin
                stalls_done = stall_requests;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("frustum_cull_test verification failed");
        $finish;
    end

    initial
    begin
        int ph;
        int n;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        func         = FUNC_BOX;
        min_x        = '0;
        min_y        = '0;
        min_z        = '0;
        max_x        = '0;
        max_y        = '0;
        max_z        = '0;
        center_x     = '0;
        center_y     = '0;
        center_z     = '0;
        radius       = '0;
        snd_idle_pct = 18;
        rcv_idle_pct = 51;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // planes come out of reset all zero, nothing can cull
        for (n = 0; n < PLANE_REGS; n++)
            cfg_access(1'b0, REG_IDX_W'(n), '0);
        offer(box_item(-32768, -32768, -32768, 32767, 32767, 32767), 1'b0);
        offer(sphere_item(-32768, 32767, 0, 32767), 1'b0);
        wait_drained();

        // axis aligned frustum: |x| <= 1000, |y| <= 1000, 0 <= z <= 5000
        // packing is {d, nz, ny, nx}
        cfg_access(1'b1, PLANE_LEFT,   {16'sd1000, 16'sd0, 16'sd0, 16'sd16384});
        cfg_access(1'b1, PLANE_RIGHT,  {16'sd1000, 16'sd0, 16'sd0, -16'sd16384});
        cfg_access(1'b1, PLANE_BOTTOM, {16'sd1000, 16'sd0, 16'sd16384, 16'sd0});
        cfg_access(1'b1, PLANE_TOP,    {16'sd1000, 16'sd0, -16'sd16384, 16'sd0});
        cfg_access(1'b1, PLANE_NEAR,   {16'sd0, 16'sd16384, 16'sd0, 16'sd0});
        cfg_access(1'b1, PLANE_FAR,    {16'sd5000, -16'sd16384, 16'sd0, 16'sd0});
        // writes past the last plane must not land anywhere
        cfg_access(1'b1, SPARE_IDX_FIRST, '1);
        cfg_access(1'b1, SPARE_IDX_LAST, '1);
        for (n = 0; n < PLANE_REGS; n++)
            cfg_access(1'b0, REG_IDX_W'(n), '0);

        offer(box_item(-10, -10, 10, 10, 10, 20), 1'b0);
        offer(box_item(-2000, -5, 5, -1500, 5, 10), 1'b0);
        offer(box_item(-2000, -5, 5, 0, 5, 10), 1'b0);
        // corner exactly on the left plane, then one unit past it
        offer(box_item(-2000, -5, 5, -1000, 5, 10), 1'b0);
        offer(box_item(-2000, -5, 5, -1001, 5, 10), 1'b0);
        // inverted in x and y, corner still taken by normal sign
        offer(box_item(-1200, 32767, 5, -1500, -32768, 10), 1'b0);
        offer(box_item(-1200, -5, 5, -1500, 5, 10), 1'b0);
        offer(box_item(-32768, -32768, -32768, 32767, 32767, 32767), 1'b0);
        offer(box_item(32767, 32767, 32767, 32767, 32767, 32767), 1'b0);
        offer(box_item(-32768, -32768, -32768, -32768, -32768, -32768), 1'b0);
        offer(sphere_item(0, 0, 100, 0), 1'b0);
        // sphere touching the left plane, then one unit further out
        offer(sphere_item(-1010, 0, 100, 10), 1'b0);
        offer(sphere_item(-1011, 0, 100, 10), 1'b0);
        offer(sphere_item(32767, 32767, 32767, 32767), 1'b0);
        offer(sphere_item(-32768, -32768, -32768, 0), 1'b0);
        offer(sphere_item(0, 0, -1, 0), 1'b0);
        offer(sphere_item(0, 0, -1, 1), 1'b0);
        wait_drained();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 3)
            begin
                snd_idle_pct = 51;
                rcv_idle_pct = 18;
            end
            else if (ph == 6)
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            load_planes(ph);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // long output stall with the sender pushing back to back
                if ((ph == 1 || ph == 7) && n == 40)
                    stall_requests++;
                offer(make_item(), (ph == 1 || ph == 7) && n >= 40 && n < 140);
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("frustum_cull_test verification clean");
        else
            $display("frustum_cull_test verification failed");
        $finish;
    end

endmodule
